/* hdl/dcit_pkg.sv */
// Shared types and constants of the deduplication chunk index table.
`timescale 1ns / 1ps

package dcit_pkg;

    localparam int HASH_W   = 64;
    localparam int SIZE_W   = 32;
    localparam int HANDLE_W = 32;
    localparam int STATUS_W = 2;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXISTS    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef logic [HASH_W-1:0]   t_hash;
    typedef logic [SIZE_W-1:0]   t_size;
    typedef logic [HANDLE_W-1:0] t_handle;
    typedef logic [STATUS_W-1:0] t_status;

    typedef struct packed {
        logic    valid;
        t_hash   rolling;
        t_hash   strong_hi;
        t_hash   strong_lo;
        t_size   size;
        t_handle bundle;
    } t_slot;

endpackage

/* hdl/dcit_ifs.sv */
// Request and response channel interfaces of the deduplication chunk index table.
`timescale 1ns / 1ps

interface dcit_req_if;
    logic            valid;
    logic            ready;
    logic            command;
    dcit_pkg::t_hash rolling_hash;
    dcit_pkg::t_hash strong_hash_hi;
    dcit_pkg::t_hash strong_hash_lo;
    dcit_pkg::t_size chunk_size;
    dcit_pkg::t_handle bundle_handle;

    modport source (
        output valid, command, rolling_hash, strong_hash_hi, strong_hash_lo,
               chunk_size, bundle_handle,
        input  ready
    );
    modport sink (
        input  valid, command, rolling_hash, strong_hash_hi, strong_hash_lo,
               chunk_size, bundle_handle,
        output ready
    );
endinterface

interface dcit_rsp_if;
    logic              valid;
    logic              ready;
    dcit_pkg::t_status status;
    dcit_pkg::t_size   found_size;
    dcit_pkg::t_handle found_bundle;

    modport source (
        output valid, status, found_size, found_bundle,
        input  ready
    );
    modport sink (
        input  valid, status, found_size, found_bundle,
        output ready
    );
endinterface

/* hdl/dcit_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module dcit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/dedup_chunk_index_table.sv */
// Deduplication chunk index: open-addressed hash table with bounded linear probing.
//
// Requests arrive on i_req as transactions carrying a command (lookup or insert),
// the 64-bit rolling hash, the 128-bit strong hash, and on insert the chunk size
// and bundle handle. Each request yields exactly one transaction on o_rsp with a
// status and, on a lookup hit, the stored size and bundle handle.
// TABLE_SLOTS must be a power of two, so the home slot is the low rolling hash bits.
// Probing reads one slot per cycle from the single slot memory, stopping at
// the first empty or matching slot, for k probes with 1 <= k <= MAX_PROBE.
// After acceptance the block passes through S_PROBE, S_CHECK for each probe and S_DONE;
// the response turns valid as it leaves S_DONE, and i_req.ready returns in the same cycle,
// so requests are processed one at a time.
// After reset the block sweeps the slot memory, clearing one valid flag per cycle,
// and holds i_req.ready low until the sweep ends.
// A response waits in the output register while o_rsp.ready is low; a new request
// is still accepted meanwhile, and its result is held until the register frees,
// with i_req.ready low until then.
`timescale 1ns / 1ps

module dedup_chunk_index_table #(
    parameter int TABLE_SLOTS = 4096,
    parameter int MAX_PROBE   = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dcit_req_if.sink   i_req,
    dcit_rsp_if.source o_rsp
);

    localparam int  SLOT_W    = $clog2(TABLE_SLOTS);
    localparam int  PROBE_W   = $clog2(MAX_PROBE + 1);
    localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(TABLE_SLOTS - 1);
    localparam logic [PROBE_W-1:0] LAST_PROBE = PROBE_W'(MAX_PROBE - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_PROBE = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [SLOT_W-1:0]   r_clr, n_clr;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [PROBE_W-1:0]  r_probe, n_probe;
    logic                r_cmd, n_cmd;
    dcit_pkg::t_hash     r_key, n_key;
    dcit_pkg::t_hash     r_hi, n_hi;
    dcit_pkg::t_hash     r_lo, n_lo;
    dcit_pkg::t_size     r_size, n_size;
    dcit_pkg::t_handle   r_bundle, n_bundle;
    dcit_pkg::t_status   r_pend_status, n_pend_status;
    dcit_pkg::t_size     r_pend_size, n_pend_size;
    dcit_pkg::t_handle   r_pend_bundle, n_pend_bundle;
    logic                r_o_valid, n_o_valid;
    dcit_pkg::t_status   r_o_status, n_o_status;
    dcit_pkg::t_size     r_o_size, n_o_size;
    dcit_pkg::t_handle   r_o_bundle, n_o_bundle;

    logic                wr_en;
    logic [SLOT_W-1:0]   wr_addr;
    dcit_pkg::t_slot     wr_data;
    logic [SLOT_W-1:0]   rd_addr;
    dcit_pkg::t_slot     rd_data;
    logic [SLOT_W-1:0]   next_slot;
    logic                slot_match;
    logic                req_accept;

    dcit_ram #(
        .WIDTH ($bits(dcit_pkg::t_slot)),
        .DEPTH (TABLE_SLOTS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign req_accept  = i_req.valid && i_req.ready;

    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.found_size   = r_o_size;
    assign o_rsp.found_bundle = r_o_bundle;

    assign next_slot  = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
    assign slot_match = rd_data.valid && (rd_data.rolling == r_key) &&
                        (rd_data.strong_hi == r_hi) && (rd_data.strong_lo == r_lo);

    always_comb begin
        n_state       = r_state;
        n_clr         = r_clr;
        n_slot        = r_slot;
        n_probe       = r_probe;
        n_cmd         = r_cmd;
        n_key         = r_key;
        n_hi          = r_hi;
        n_lo          = r_lo;
        n_size        = r_size;
        n_bundle      = r_bundle;
        n_pend_status = r_pend_status;
        n_pend_size   = r_pend_size;
        n_pend_bundle = r_pend_bundle;
        n_o_valid     = r_o_valid && !o_rsp.ready;
        n_o_status    = r_o_status;
        n_o_size      = r_o_size;
        n_o_bundle    = r_o_bundle;

        wr_en             = 1'b0;
        wr_addr           = r_slot;
        wr_data.valid     = 1'b1;
        wr_data.rolling   = r_key;
        wr_data.strong_hi = r_hi;
        wr_data.strong_lo = r_lo;
        wr_data.size      = r_size;
        wr_data.bundle    = r_bundle;
        rd_addr           = r_slot;

        case (r_state)
            S_CLEAR: begin
                wr_en         = 1'b1;
                wr_addr       = r_clr;
                wr_data.valid = 1'b0;
                n_clr         = r_clr + 1'b1;
                if (r_clr == LAST_SLOT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_accept) begin
                    n_cmd    = i_req.command;
                    n_key    = i_req.rolling_hash;
                    n_hi     = i_req.strong_hash_hi;
                    n_lo     = i_req.strong_hash_lo;
                    n_size   = i_req.chunk_size;
                    n_bundle = i_req.bundle_handle;
                    n_probe  = '0;
                    n_slot   = i_req.rolling_hash[SLOT_W-1:0];
                    n_state  = S_PROBE;
                end
            end
            S_PROBE: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                rd_addr       = next_slot;
                n_pend_size   = '0;
                n_pend_bundle = '0;
                if (!rd_data.valid) begin
                    if (r_cmd == dcit_pkg::CMD_INSERT) begin
                        wr_en         = 1'b1;
                        n_pend_status = dcit_pkg::ST_FOUND;
                    end else begin
                        n_pend_status = dcit_pkg::ST_NOT_FOUND;
                    end
                    n_state = S_DONE;
                end else if (slot_match) begin
                    if (r_cmd == dcit_pkg::CMD_INSERT) begin
                        n_pend_status = dcit_pkg::ST_EXISTS;
                    end else begin
                        n_pend_status = dcit_pkg::ST_FOUND;
                        n_pend_size   = rd_data.size;
                        n_pend_bundle = rd_data.bundle;
                    end
                    n_state = S_DONE;
                end else if (r_probe == LAST_PROBE) begin
                    n_pend_status = (r_cmd == dcit_pkg::CMD_INSERT) ?
                                    dcit_pkg::ST_FULL : dcit_pkg::ST_NOT_FOUND;
                    n_state = S_DONE;
                end else begin
                    n_slot  = next_slot;
                    n_probe = r_probe + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_o_valid || o_rsp.ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_pend_status;
                    n_o_size   = r_pend_size;
                    n_o_bundle = r_pend_bundle;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot        <= n_slot;
        r_probe       <= n_probe;
        r_cmd         <= n_cmd;
        r_key         <= n_key;
        r_hi          <= n_hi;
        r_lo          <= n_lo;
        r_size        <= n_size;
        r_bundle      <= n_bundle;
        r_pend_status <= n_pend_status;
        r_pend_size   <= n_pend_size;
        r_pend_bundle <= n_pend_bundle;
        r_o_status    <= n_o_status;
        r_o_size      <= n_o_size;
        r_o_bundle    <= n_o_bundle;
    end

endmodule

/* hdl/dcit_checker.sv */
// Port-level assertions of the deduplication chunk index table and their binding.
`timescale 1ns / 1ps

module dcit_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              i_req_ready,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input dcit_pkg::t_status i_rsp_status,
    input dcit_pkg::t_size   i_rsp_size,
    input dcit_pkg::t_handle i_rsp_bundle
);

    // A stalled response keeps its valid flag and its contents.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_size) &&
            $stable(i_rsp_bundle))
        else $error("response changed while stalled");

    // Only a lookup hit carries a size and a bundle handle.
    a_rsp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != dcit_pkg::ST_FOUND) |->
            (i_rsp_size == '0) && (i_rsp_bundle == '0))
        else $error("non-hit response carries data");

    // Only one request is in flight, so ready drops after each acceptance.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while another is in flight");

    // The table is swept clear after reset before any request is taken.
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_req_ready && !i_rsp_valid)
        else $error("request taken during the clearing sweep");

endmodule

bind dedup_chunk_index_table dcit_checker u_dcit_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_size   (o_rsp.found_size),
    .i_rsp_bundle (o_rsp.found_bundle)
);

/* test/tb_top.sv */
// Self-checking testbench for the deduplication chunk index table.
`timescale 1ns / 1ps

module tb_top;

    localparam int TB_SLOTS       = 4096;
    localparam int TB_PROBE       = 8;
    localparam int SLOT_W         = $clog2(TB_SLOTS);
    localparam int CLK_HALF       = 2;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 32;
    localparam int FULL_HOME      = 100;
    localparam int HOT_COUNT      = 32;

    typedef struct {
        dcit_pkg::t_hash rolling;
        dcit_pkg::t_hash hi;
        dcit_pkg::t_hash lo;
    } t_chunk_key;

    typedef struct {
        dcit_pkg::t_status status;
        dcit_pkg::t_size   size;
        dcit_pkg::t_handle bundle;
    } t_reply;

    logic i_clk;
    logic i_rst_n;

    dcit_req_if req_ch ();
    dcit_rsp_if rsp_ch ();

    dedup_chunk_index_table #(
        .TABLE_SLOTS (TB_SLOTS),
        .MAX_PROBE   (TB_PROBE)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    bit                tbl_used    [TB_SLOTS];
    dcit_pkg::t_hash   tbl_rolling [TB_SLOTS];
    dcit_pkg::t_hash   tbl_hi      [TB_SLOTS];
    dcit_pkg::t_hash   tbl_lo      [TB_SLOTS];
    dcit_pkg::t_size   tbl_size    [TB_SLOTS];
    dcit_pkg::t_handle tbl_bundle  [TB_SLOTS];

    t_reply      chunk_replies [$];
    t_chunk_key  known_keys [$];
    int unsigned hot_base [HOT_COUNT];
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned hold_len       = 0;
    bit          req_gaps_on    = 1'b1;
    bit          rsp_stalls_on  = 1'b1;

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    function automatic t_reply probe_table(logic cmd, t_chunk_key key, dcit_pkg::t_size sz,
                                           dcit_pkg::t_handle bh);
        t_reply      ans;
        int unsigned slot;
        bit          done;
        ans.status = (cmd == dcit_pkg::CMD_INSERT) ? dcit_pkg::ST_FULL
                                                   : dcit_pkg::ST_NOT_FOUND;
        ans.size   = '0;
        ans.bundle = '0;
        slot = int'(key.rolling % 64'(TB_SLOTS));
        done = 1'b0;
        for (int p = 0; p < TB_PROBE && !done; p++) begin
            if (!tbl_used[slot]) begin
                if (cmd == dcit_pkg::CMD_INSERT) begin
                    tbl_used[slot]    = 1'b1;
                    tbl_rolling[slot] = key.rolling;
                    tbl_hi[slot]      = key.hi;
                    tbl_lo[slot]      = key.lo;
                    tbl_size[slot]    = sz;
                    tbl_bundle[slot]  = bh;
                    ans.status = dcit_pkg::ST_FOUND;
                end else begin
                    ans.status = dcit_pkg::ST_NOT_FOUND;
                end
                done = 1'b1;
            end else if (tbl_rolling[slot] == key.rolling && tbl_hi[slot] == key.hi &&
                         tbl_lo[slot] == key.lo) begin
                if (cmd == dcit_pkg::CMD_INSERT) begin
                    ans.status = dcit_pkg::ST_EXISTS;
                end else begin
                    ans.status = dcit_pkg::ST_FOUND;
                    ans.size   = tbl_size[slot];
                    ans.bundle = tbl_bundle[slot];
                end
                done = 1'b1;
            end else begin
                slot = (slot + 1) % TB_SLOTS;
            end
        end
        return ans;
    endfunction

    function automatic t_chunk_key fresh_key(bit hot);
        t_chunk_key key;
        key.rolling = {$urandom, $urandom};
        key.hi      = {$urandom, $urandom};
        key.lo      = {$urandom, $urandom};
        if (hot) begin
            key.rolling[SLOT_W-1:0] =
                SLOT_W'((hot_base[$urandom_range(0, HOT_COUNT-1)] + $urandom_range(0, 3))
                        % TB_SLOTS);
        end
        return key;
    endfunction

    task automatic note_mismatch(string field, logic [63:0] got_v, logic [63:0] want_v);
        $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, field, got_v, want_v);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_reply     want;
        t_chunk_key seen;
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (chunk_replies.size() == 0) begin
                    note_mismatch("unexpected response, status", 64'(rsp_ch.status), '0);
                end else begin
                    want = chunk_replies.pop_front();
                    if (rsp_ch.status !== want.status)
                        note_mismatch("status", 64'(rsp_ch.status), 64'(want.status));
                    if (rsp_ch.found_size !== want.size)
                        note_mismatch("found_size", 64'(rsp_ch.found_size),
                                      64'(want.size));
                    if (rsp_ch.found_bundle !== want.bundle)
                        note_mismatch("found_bundle", 64'(rsp_ch.found_bundle),
                                      64'(want.bundle));
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                seen.rolling = req_ch.rolling_hash;
                seen.hi      = req_ch.strong_hash_hi;
                seen.lo      = req_ch.strong_hash_lo;
                chunk_replies.push_back(probe_table(req_ch.command, seen,
                    req_ch.chunk_size, req_ch.bundle_handle));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // The response side stalls at random; a requested long hold is counted here.
    initial begin : response_sink
        int unsigned stall;
        rsp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_len > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (hold_len) @(negedge i_clk);
                hold_len = 0;
            end else begin
                stall = rsp_stalls_on ? $urandom_range(0, 5) : 0;
                if (stall > 0) begin
                    rsp_ch.ready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_ch.valid && rsp_ch.ready) && hold_len == 0);
            @(negedge i_clk);
        end
    end

    task automatic send_item(logic cmd, t_chunk_key key, dcit_pkg::t_size sz,
                             dcit_pkg::t_handle bh);
        int unsigned gap;
        gap = req_gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.command        <= cmd;
        req_ch.rolling_hash   <= key.rolling;
        req_ch.strong_hash_hi <= key.hi;
        req_ch.strong_hash_lo <= key.lo;
        req_ch.chunk_size     <= sz;
        req_ch.bundle_handle  <= bh;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic wait_all_answered();
        req_ch.valid <= 1'b0;
        while (chunk_replies.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_empty_lookups();
        send_item(dcit_pkg::CMD_LOOKUP, '{default: '0}, '0, '0);
        send_item(dcit_pkg::CMD_LOOKUP, '{default: '1}, '1, '1);
    endtask

    // The all-ones key homes on the last slot, so its twin wraps past slot zero.
    task automatic test_insert_and_find();
        t_chunk_key zero_key;
        t_chunk_key ones_key;
        t_chunk_key twin;
        t_chunk_key probe;
        zero_key = '{default: '0};
        ones_key = '{default: '1};
        send_item(dcit_pkg::CMD_INSERT, zero_key, '1, '0);
        send_item(dcit_pkg::CMD_INSERT, ones_key, '0, '1);
        send_item(dcit_pkg::CMD_LOOKUP, zero_key, '0, '0);
        send_item(dcit_pkg::CMD_LOOKUP, ones_key, '0, '0);
        send_item(dcit_pkg::CMD_INSERT, zero_key, $urandom, $urandom);
        twin = ones_key;
        twin.lo[0] = 1'b0;
        send_item(dcit_pkg::CMD_INSERT, twin, $urandom, $urandom);
        send_item(dcit_pkg::CMD_LOOKUP, twin, '0, '0);
        probe = ones_key;
        probe.hi[63] = 1'b0;
        send_item(dcit_pkg::CMD_LOOKUP, probe, '1, '1);
        probe = zero_key;
        probe.lo[5] = 1'b1;
        send_item(dcit_pkg::CMD_LOOKUP, probe, '0, '0);
    endtask

    task automatic test_full_window();
        t_chunk_key chain [TB_PROBE+1];
        t_chunk_key stranger;
        for (int i = 0; i <= TB_PROBE; i++) begin
            chain[i] = fresh_key(1'b0);
            chain[i].rolling[SLOT_W-1:0] = SLOT_W'(FULL_HOME);
            if (i == 1) chain[i].rolling = chain[0].rolling;
            send_item(dcit_pkg::CMD_INSERT, chain[i], $urandom, $urandom);
        end
        stranger = fresh_key(1'b0);
        stranger.rolling[SLOT_W-1:0] = SLOT_W'(FULL_HOME);
        send_item(dcit_pkg::CMD_LOOKUP, stranger, '0, '0);
        send_item(dcit_pkg::CMD_LOOKUP, chain[TB_PROBE-1], '0, '0);
        send_item(dcit_pkg::CMD_LOOKUP, chain[TB_PROBE], '0, '0);
    endtask

    // Most keys land in a few crowded neighbourhoods so that chains grow and windows fill.
    task automatic test_random_traffic(int unsigned count);
        t_chunk_key  key;
        logic        cmd;
        int unsigned pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            cmd  = dcit_pkg::CMD_INSERT;
            key  = fresh_key($urandom_range(0, 2) != 0);
            if (pick < 35 || known_keys.size() == 0) begin
                known_keys.push_back(key);
            end else if (pick < 50) begin
                key = known_keys[$urandom_range(0, known_keys.size() - 1)];
                cmd = dcit_pkg::CMD_LOOKUP;
            end else if (pick < 60) begin
                key = known_keys[$urandom_range(0, known_keys.size() - 1)];
            end else if (pick < 72) begin
                key = known_keys[$urandom_range(0, known_keys.size() - 1)];
                if ($urandom_range(0, 1) != 0)
                    key.hi[$urandom_range(0, 63)] ^= 1'b1;
                else
                    key.lo[$urandom_range(0, 63)] ^= 1'b1;
                cmd = 1'($urandom_range(0, 1));
                if (cmd == dcit_pkg::CMD_INSERT) known_keys.push_back(key);
            end else if (pick < 88) begin
                cmd = dcit_pkg::CMD_LOOKUP;
            end else begin
                key = fresh_key(1'b0);
                cmd = 1'($urandom_range(0, 1));
            end
            send_item(cmd, key, $urandom, $urandom);
        end
    endtask

    task automatic test_back_to_back(int unsigned count);
        req_gaps_on   = 1'b0;
        rsp_stalls_on = 1'b0;
        test_random_traffic(count);
        req_gaps_on   = 1'b1;
        rsp_stalls_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        t_chunk_key key;
        wait_all_answered();
        req_gaps_on = 1'b0;
        hold_len    = LONG_HOLD;
        for (int i = 0; i < 6; i++) begin
            key = fresh_key(1'b1);
            send_item(dcit_pkg::CMD_INSERT, key, $urandom, $urandom);
            send_item(dcit_pkg::CMD_LOOKUP, key, $urandom, $urandom);
        end
        req_gaps_on = 1'b1;
        wait_all_answered();
    endtask

    initial begin : run_tests
        i_rst_n               = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.command        = dcit_pkg::CMD_LOOKUP;
        req_ch.rolling_hash   = '0;
        req_ch.strong_hash_hi = '0;
        req_ch.strong_hash_lo = '0;
        req_ch.chunk_size     = '0;
        req_ch.bundle_handle  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_lookups();
        test_insert_and_find();
        test_full_window();

        hot_base[0] = 0;
        hot_base[1] = TB_SLOTS - 2;
        for (int i = 2; i < HOT_COUNT; i++) hot_base[i] = $urandom_range(0, TB_SLOTS - 1);

        test_random_traffic(300);
        test_back_to_back(150);
        test_output_backpressure();
        test_random_traffic(288);

        wait_all_answered();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (chunk_replies.size() != 0)
            note_mismatch("responses never delivered", 64'(chunk_replies.size()), '0);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
